### hw/rtl/sjn_pkg.sv
// Package with the shared types and constants of the shortest-job-next allocator.
`default_nettype none

package sjn_pkg;

  // Queue depth, the widths that follow from it and the field widths.
  localparam int PROC_CNT = 16;
  localparam int IDX_W    = $clog2(PROC_CNT);
  localparam int CNT_W    = $clog2(PROC_CNT + 1);
  localparam int ID_W     = 4;
  localparam int AMT_W    = 8;
  localparam int TIME_W   = 16;

  // Free count loaded at reset.
  localparam logic [AMT_W-1:0] RESET_TOTAL = AMT_W'(16);

  // Result status codes.
  typedef enum logic [1:0] {
    ST_NONE   = 2'd0,
    ST_GRANT  = 2'd1,
    ST_QUEUED = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_REQ,
    S_REL,
    S_SCAN,
    S_FIN
  } state_t;

  // One waiting request.
  typedef struct packed {
    logic [TIME_W-1:0] job_time;
    logic [AMT_W-1:0]  amount;
    logic [ID_W-1:0]   id;
  } entry_t;

endpackage

`default_nettype wire

### hw/rtl/sjn_multi_resource_allocator_core.sv
// Top level of the shortest-job-next resource allocator.
`default_nettype none

// Usage:
// A word is taken on the input side at a clock edge where start is high and
// busy is low. in_mode 0 requests in_amount resources for in_process_id with
// priority key in_job_time; in_mode 1 releases in_amount resources.
// Every word yields one result word, shown for exactly one cycle with
// out_valid high: status, granted id, free count and queue occupancy.
// A request shows its result after the S_REQ state. A release passes through
// S_REL, then S_SCAN for each waiting request (up to 16), then S_FIN:
// one shared comparator walks the queue, one entry per cycle, to find the
// shortest job, oldest first on equal keys. busy drops as the result
// appears, so the next word can be taken at the edge that ends the result
// cycle. Waiters are kept in arrival order; a grant from the queue closes
// the gap by shifting the later entries down by one.
// cfg_we with cfg_wdata sets the pool size and reloads the free count; the
// user must write it only while the block is idle, and the block itself
// does not enforce this.
// Synchronous reset (rst_n low) empties the queue and loads a free count of
// 16. The receiver cannot stall: each result is taken in the cycle it is
// shown.
module sjn_multi_resource_allocator_core (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         start,
  output logic                        busy,
  input  wire                         in_mode,
  input  wire [sjn_pkg::TIME_W-1:0]   in_job_time,
  input  wire [sjn_pkg::AMT_W-1:0]    in_amount,
  input  wire [sjn_pkg::ID_W-1:0]     in_process_id,
  output logic                        out_valid,
  output logic [1:0]                  out_status,
  output logic [sjn_pkg::ID_W-1:0]    out_granted_id,
  output logic [sjn_pkg::AMT_W-1:0]   out_available_after,
  output logic [sjn_pkg::CNT_W-1:0]   out_waiting_count,
  input  wire                         cfg_we,
  input  wire [sjn_pkg::AMT_W-1:0]    cfg_wdata
);
  import sjn_pkg::*;

  state_t             state_r, state_nxt;
  entry_t             item_r;
  logic [AMT_W-1:0]   free_r;
  logic [CNT_W-1:0]   occ_r;
  entry_t             entries_r [PROC_CNT];
  logic [IDX_W-1:0]   scan_idx_r;
  entry_t             best_r;
  logic [IDX_W-1:0]   best_idx_r;
  logic               out_valid_r;
  status_t            out_status_r;
  logic [ID_W-1:0]    out_id_r;

  logic               accept;
  entry_t             scan_rd;
  logic               scan_last;
  logic               scan_better;
  logic [AMT_W:0]     rel_sum;
  logic               req_fits;
  logic               head_fits;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // Shared compare unit: one queue entry against the best found so far.
  assign scan_rd     = entries_r[scan_idx_r];
  assign scan_last   = ({1'b0, scan_idx_r} == CNT_W'(occ_r - CNT_W'(1)));
  assign scan_better = (scan_idx_r == '0) || (scan_rd.job_time < best_r.job_time);

  assign rel_sum   = {1'b0, free_r} + {1'b0, item_r.amount};
  assign req_fits  = (item_r.amount <= free_r);
  assign head_fits = (occ_r != '0) && (best_r.amount <= free_r);

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = in_mode ? S_REL : S_REQ;
        end
      end
      S_REQ:  state_nxt = S_IDLE;
      S_REL:  state_nxt = (occ_r == '0) ? S_FIN : S_SCAN;
      S_SCAN: state_nxt = scan_last ? S_FIN : S_SCAN;
      S_FIN:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control state: free count, occupancy and the result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r      <= RESET_TOTAL;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        free_r <= cfg_wdata;
      end
      case (state_r)
        S_REQ: begin
          out_valid_r <= 1'b1;
          if (req_fits) begin
            free_r <= free_r - item_r.amount;
          end else if (occ_r < CNT_W'(PROC_CNT)) begin
            occ_r <= occ_r + CNT_W'(1);
          end
        end
        S_REL: begin
          free_r <= rel_sum[AMT_W] ? {AMT_W{1'b1}} : rel_sum[AMT_W-1:0];
        end
        S_FIN: begin
          out_valid_r <= 1'b1;
          if (head_fits) begin
            free_r <= free_r - best_r.amount;
            occ_r  <= occ_r - CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Payload: latched word, queue storage, scan registers and result fields.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.job_time <= in_job_time[TIME_W-1:0];
      item_r.amount   <= in_amount;
      item_r.id       <= in_process_id;
    end
    case (state_r)
      S_REQ: begin
        if (req_fits) begin
          out_status_r <= ST_GRANT;
          out_id_r     <= item_r.id;
        end else if (occ_r < CNT_W'(PROC_CNT)) begin
          entries_r[occ_r[IDX_W-1:0]] <= item_r;
          out_status_r <= ST_QUEUED;
          out_id_r     <= '0;
        end else begin
          out_status_r <= ST_FULL;
          out_id_r     <= '0;
        end
      end
      S_REL: begin
        scan_idx_r <= '0;
      end
      S_SCAN: begin
        // Strict less-than keeps the oldest waiter on equal keys.
        if (scan_better) begin
          best_r     <= scan_rd;
          best_idx_r <= scan_idx_r;
        end
        scan_idx_r <= scan_idx_r + IDX_W'(1);
      end
      S_FIN: begin
        if (head_fits) begin
          out_status_r <= ST_GRANT;
          out_id_r     <= best_r.id;
          // Close the gap so the queue stays in arrival order.
          for (int i = 0; i < PROC_CNT - 1; i++) begin
            if (IDX_W'(i) >= best_idx_r) begin
              entries_r[i] <= entries_r[i+1];
            end
          end
        end else begin
          out_status_r <= ST_NONE;
          out_id_r     <= '0;
        end
      end
      default: ;
    endcase
  end

  // Result ports.
  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_granted_id      = out_id_r;
  assign out_available_after = free_r;
  assign out_waiting_count   = occ_r;

`ifndef SYNTHESIS
  // A result only follows the decision step of a request or a release.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == S_REQ || $past(state_r) == S_FIN))
    else $error("result strobe without a decision step");

  // The queue never holds more than its depth.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(PROC_CNT))
    else $error("queue occupancy beyond depth");

  // A grant of a queued request removes exactly one waiter.
  a_grant_pops: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && head_fits) |=> (occ_r == $past(occ_r) - CNT_W'(1)))
    else $error("queue grant did not remove one waiter");

  // A release scan always starts from the first slot.
  a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REL) |=> (scan_idx_r == '0))
    else $error("queue scan did not start at slot zero");
`endif

endmodule

`default_nettype wire

### dv/tb_sjn_multi_resource_allocator_core.sv
// Self-checking testbench for the shortest-job-next resource allocator core.
module tb_sjn_multi_resource_allocator_core;
  import sjn_pkg::*;

  localparam logic MODE_REQ = 1'b0;
  localparam logic MODE_REL = 1'b1;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASES = 8;
  localparam int WORDS_PER_PHASE = 228;
  localparam int TAIL_CYCLES = 30;

  // One result word as the block should show it.
  typedef struct packed {
    status_t          status;
    logic [ID_W-1:0]  gid;
    logic [AMT_W-1:0] avail;
    logic [CNT_W-1:0] waiting;
  } alloc_result_t;

  // One input word, with an optional hand-written expectation.
  typedef struct packed {
    logic              mode;
    logic [TIME_W-1:0] job_time;
    logic [AMT_W-1:0]  amount;
    logic [ID_W-1:0]   pid;
    logic              typed;
    alloc_result_t     res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic in_mode = 1'b0;
  logic [TIME_W-1:0] in_job_time = '0;
  logic [AMT_W-1:0] in_amount = '0;
  logic [ID_W-1:0] in_process_id = '0;
  logic cfg_we = 1'b0;
  logic [AMT_W-1:0] cfg_wdata = '0;
  logic busy;
  logic out_valid;
  logic [1:0] out_status;
  logic [ID_W-1:0] out_granted_id;
  logic [AMT_W-1:0] out_available_after;
  logic [CNT_W-1:0] out_waiting_count;

  // Predicted allocator state: pool size, free count and waiters in arrival order.
  logic [AMT_W-1:0] pool_total = RESET_TOTAL;
  logic [AMT_W-1:0] pool_free = RESET_TOTAL;
  entry_t waiters[$];

  alloc_result_t pending_results[$];
  alloc_result_t want;
  stim_row_t dir_rows[$];
  int err_count = 0;
  int cycle_count = 0;
  int words_sent = 0;
  int resizes = 0;
  int tally[4] = '{0, 0, 0, 0};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sjn_multi_resource_allocator_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_mode             (in_mode),
    .in_job_time         (in_job_time),
    .in_amount           (in_amount),
    .in_process_id       (in_process_id),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_granted_id      (out_granted_id),
    .out_available_after (out_available_after),
    .out_waiting_count   (out_waiting_count),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata)
  );

  // Works out the result of one word and advances the predicted state.
  function automatic alloc_result_t predict_allocation(logic mode, logic [TIME_W-1:0] jt,
                                                       logic [AMT_W-1:0] amt,
                                                       logic [ID_W-1:0] pid);
    alloc_result_t r;
    entry_t fresh;
    int best;
    int sum;
    r.status = ST_NONE;
    r.gid = '0;
    if (mode == MODE_REQ) begin
      if (amt <= pool_free) begin
        pool_free = pool_free - amt;
        r.status = ST_GRANT;
        r.gid = pid;
      end else if (waiters.size() < PROC_CNT) begin
        fresh.job_time = jt;
        fresh.amount = amt;
        fresh.id = pid;
        waiters.push_back(fresh);
        r.status = ST_QUEUED;
      end else begin
        r.status = ST_FULL;
      end
    end else begin
      // Give back the amount, saturating, then try the shortest waiter only.
      sum = pool_free + amt;
      pool_free = (sum > 255) ? {AMT_W{1'b1}} : AMT_W'(sum);
      if (waiters.size() > 0) begin
        best = 0;
        // Strict compare keeps the oldest waiter on equal job times.
        for (int i = 1; i < waiters.size(); i++) begin
          if (waiters[i].job_time < waiters[best].job_time) best = i;
        end
        if (waiters[best].amount <= pool_free) begin
          pool_free = pool_free - waiters[best].amount;
          r.status = ST_GRANT;
          r.gid = waiters[best].id;
          waiters.delete(best);
        end
      end
    end
    r.avail = pool_free;
    r.waiting = CNT_W'(waiters.size());
    return r;
  endfunction

  // Builds a random word; well-formed amounts dominate, with extremes mixed in.
  function automatic stim_row_t random_word(int req_pct);
    stim_row_t w;
    int k;
    w = '0;
    w.mode = ($urandom_range(0, 99) < req_pct) ? MODE_REQ : MODE_REL;
    k = $urandom_range(0, 9);
    if (k < 6) w.job_time = TIME_W'($urandom_range(0, 7));
    else if (k < 9) w.job_time = TIME_W'($urandom());
    else w.job_time = $urandom_range(0, 1) ? {TIME_W{1'b1}} : '0;
    k = $urandom_range(0, 9);
    if (k < 7) begin
      w.amount = (w.mode == MODE_REQ) ? AMT_W'($urandom_range(0, pool_total))
                                      : AMT_W'($urandom_range(1, pool_total));
    end else if (k == 7) begin
      w.amount = '0;
    end else if (k == 8) begin
      w.amount = {AMT_W{1'b1}};
    end else begin
      w.amount = AMT_W'($urandom());
    end
    w.pid = ID_W'($urandom_range(0, 15));
    return w;
  endfunction

  task automatic add_row(logic mode, logic [TIME_W-1:0] jt, logic [AMT_W-1:0] amt,
                         logic [ID_W-1:0] pid, logic typed, status_t st,
                         logic [ID_W-1:0] gid, logic [AMT_W-1:0] avail,
                         logic [CNT_W-1:0] waiting);
    stim_row_t w;
    w.mode = mode;
    w.job_time = jt;
    w.amount = amt;
    w.pid = pid;
    w.typed = typed;
    w.res.status = st;
    w.res.gid = gid;
    w.res.avail = avail;
    w.res.waiting = waiting;
    dir_rows.push_back(w);
  endtask

  // Offers one word and records its expectation once the block takes it.
  task automatic send_word(input stim_row_t w);
    alloc_result_t pred;
    in_mode <= w.mode;
    in_job_time <= w.job_time;
    in_amount <= w.amount;
    in_process_id <= w.pid;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    pred = predict_allocation(w.mode, w.job_time, w.amount, w.pid);
    if (w.typed) pred = w.res;
    pending_results.push_back(pred);
    tally[pred.status]++;
    words_sent++;
  endtask

  // Random idle time on the input side: mostly none or short, rarely long.
  task automatic sender_gap(input bit steady);
    int k;
    int gap;
    k = $urandom_range(0, 99);
    if (steady || k < 55) gap = 0;
    else if (k < 90) gap = $urandom_range(1, 3);
    else if (k < 98) gap = $urandom_range(4, 10);
    else gap = $urandom_range(20, 60);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Pool size is only changed with the block idle; it reloads the free count.
  task automatic resize_pool(input logic [AMT_W-1:0] size);
    wait_drained();
    cfg_wdata <= size;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    pool_total = size;
    pool_free = size;
    resizes++;
  endtask

  // Compare every result word with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: status %0d id %0d", out_status, out_granted_id);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          err_count++;
        end
        if (out_granted_id !== want.gid) begin
          $error("granted_id: expected %0d, got %0d", want.gid, out_granted_id);
          err_count++;
        end
        if (out_available_after !== want.avail) begin
          $error("available_after: expected %0d, got %0d", want.avail, out_available_after);
          err_count++;
        end
        if (out_waiting_count !== want.waiting) begin
          $error("waiting_count: expected %0d, got %0d", want.waiting, out_waiting_count);
          err_count++;
        end
      end
    end
  end

  // Guard against a hang.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_sjn_multi_resource_allocator_core: FAIL");
      $finish;
    end
  end

  initial begin
    logic [AMT_W-1:0] size;
    int req_pct;
    bit steady;
    req_pct = 50;
    steady = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words at the reset pool of 16: zero amount, full pool, a full
    // queue, a release whose head does not fit, tie order and saturation.
    add_row(MODE_REQ, 16'h0000, 8'd0,   4'd0,  1, ST_GRANT,  4'd0,  8'd16,  5'd0);
    add_row(MODE_REQ, 16'hFFFF, 8'd16,  4'd15, 1, ST_GRANT,  4'd15, 8'd0,   5'd0);
    add_row(MODE_REQ, 16'd100,  8'd1,   4'd1,  1, ST_QUEUED, 4'd0,  8'd0,   5'd1);
    add_row(MODE_REQ, 16'hFFFF, 8'd255, 4'd2,  1, ST_QUEUED, 4'd0,  8'd0,   5'd2);
    add_row(MODE_REQ, 16'd100,  8'd2,   4'd3,  1, ST_QUEUED, 4'd0,  8'd0,   5'd3);
    add_row(MODE_REQ, 16'h0000, 8'd3,   4'd4,  1, ST_QUEUED, 4'd0,  8'd0,   5'd4);
    add_row(MODE_REQ, 16'h8000, 8'd128, 4'd5,  1, ST_QUEUED, 4'd0,  8'd0,   5'd5);
    add_row(MODE_REQ, 16'h7FFF, 8'd127, 4'd6,  1, ST_QUEUED, 4'd0,  8'd0,   5'd6);
    add_row(MODE_REQ, 16'h5555, 8'd1,   4'd7,  1, ST_QUEUED, 4'd0,  8'd0,   5'd7);
    add_row(MODE_REQ, 16'hAAAA, 8'd2,   4'd8,  1, ST_QUEUED, 4'd0,  8'd0,   5'd8);
    add_row(MODE_REQ, 16'd200,  8'd4,   4'd9,  1, ST_QUEUED, 4'd0,  8'd0,   5'd9);
    add_row(MODE_REQ, 16'd200,  8'd8,   4'd10, 1, ST_QUEUED, 4'd0,  8'd0,   5'd10);
    add_row(MODE_REQ, 16'd300,  8'd16,  4'd11, 1, ST_QUEUED, 4'd0,  8'd0,   5'd11);
    add_row(MODE_REQ, 16'hFFFE, 8'd32,  4'd12, 1, ST_QUEUED, 4'd0,  8'd0,   5'd12);
    add_row(MODE_REQ, 16'd1000, 8'd64,  4'd13, 1, ST_QUEUED, 4'd0,  8'd0,   5'd13);
    add_row(MODE_REQ, 16'h0F0F, 8'd85,  4'd14, 1, ST_QUEUED, 4'd0,  8'd0,   5'd14);
    add_row(MODE_REQ, 16'hF0F0, 8'd170, 4'd15, 1, ST_QUEUED, 4'd0,  8'd0,   5'd15);
    add_row(MODE_REQ, 16'd250,  8'd5,   4'd0,  1, ST_QUEUED, 4'd0,  8'd0,   5'd16);
    add_row(MODE_REQ, 16'h1234, 8'd1,   4'd9,  1, ST_FULL,   4'd0,  8'd0,   5'd16);
    add_row(MODE_REL, 16'h0000, 8'd2,   4'd15, 1, ST_NONE,   4'd0,  8'd2,   5'd16);
    add_row(MODE_REL, 16'h0000, 8'd1,   4'd15, 1, ST_GRANT,  4'd4,  8'd0,   5'd15);
    add_row(MODE_REL, 16'hFFFF, 8'd1,   4'd15, 1, ST_GRANT,  4'd1,  8'd0,   5'd14);
    add_row(MODE_REL, 16'h0000, 8'd255, 4'd15, 1, ST_GRANT,  4'd3,  8'd253, 5'd13);
    add_row(MODE_REL, 16'h0000, 8'd255, 4'd0,  0, ST_NONE,   4'd0,  8'd0,   5'd0);
    add_row(MODE_REL, 16'h0000, 8'd0,   4'd0,  0, ST_NONE,   4'd0,  8'd0,   5'd0);
    foreach (dir_rows[i]) begin
      send_word(dir_rows[i]);
      sender_gap(1'b0);
    end

    // Random phases, each at its own pool size, the extremes among them.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: size = 8'd1;
        1: size = 8'd255;
        2: size = 8'd8;
        3: size = 8'd2;
        6: size = 8'd255;
        default: size = AMT_W'($urandom_range(1, 40));
      endcase
      resize_pool(size);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        // Shift the request/release balance now and then so the queue both
        // fills up and drains.
        if (n % 40 == 0) begin
          req_pct = $urandom_range(30, 80);
          steady = ($urandom_range(0, 3) == 0);
        end
        send_word(random_word(req_pct));
        if ($urandom_range(0, 99) == 0) wait_drained();
        else sender_gap(steady);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Ran %0d words over %0d pool sizes after the reset pool.", words_sent, resizes);
    $display("Results: %0d grants, %0d queued, %0d queue-full rejects, %0d releases with no grant.",
             tally[ST_GRANT], tally[ST_QUEUED], tally[ST_FULL], tally[ST_NONE]);
    if (err_count == 0) begin
      $display("tb_sjn_multi_resource_allocator_core: PASS");
    end else begin
      $display("tb_sjn_multi_resource_allocator_core: FAIL");
    end
    $finish;
  end

endmodule
